FILE: rtl/dilp_pkg.sv
// Shared constants and types for the decimal integer list parser.
`default_nettype none

package dilp_pkg;

  localparam int VALUE_BITS_DEFAULT = 32;
  localparam int COUNT_BITS_DEFAULT = 16;

  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_WS_LO = 8'h09;
  localparam logic [7:0] CH_WS_HI = 8'h0D;
  localparam int         RADIX    = 10;

  typedef enum logic [2:0] {
    KIND_VALUE    = 3'd0,
    KIND_OK       = 3'd1,
    KIND_MISMATCH = 3'd2,
    KIND_SYNTAX   = 3'd3,
    KIND_TRUNC    = 3'd4,
    KIND_OVERFLOW = 3'd5
  } kind_t;

  // Up to two results per byte; slot one is only used when slot zero is.
  typedef struct packed {
    logic  push0;
    logic  push1;
    kind_t kind0;
    kind_t kind1;
  } push_t;

endpackage

`default_nettype wire

FILE: rtl/dilp_if.sv
// Handshake interfaces for the text byte channel and the result channel.
`default_nettype none

interface dilp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_text;

  modport source (output valid, output ch, output end_of_text, input ready);
  modport sink (input valid, input ch, input end_of_text, output ready);
endinterface

interface dilp_result_if #(
  parameter int VALUE_BITS = dilp_pkg::VALUE_BITS_DEFAULT,
  parameter int COUNT_BITS = dilp_pkg::COUNT_BITS_DEFAULT
);
  logic                         valid;
  logic                         ready;
  logic [2:0]                   kind;
  logic signed [VALUE_BITS-1:0] value;
  logic [COUNT_BITS-1:0]        index;
  logic                         last;

  modport source (output valid, output kind, output value, output index, output last,
                  input ready);
  modport sink (input valid, input kind, input value, input index, input last,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/dilp_parser.sv
// Tokenizer state machine: decodes one byte per cycle while accept is high into zero, one or two results.
`default_nettype none

module dilp_parser #(
  parameter int VALUE_BITS = dilp_pkg::VALUE_BITS_DEFAULT,
  parameter int COUNT_BITS = dilp_pkg::COUNT_BITS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wr_en,
  input  wire logic [COUNT_BITS-1:0]        cfg_wr_data,
  input  wire logic                         accept,
  input  wire logic [7:0]                   ch,
  input  wire logic                         end_of_text,
  output dilp_pkg::push_t                   push,
  output logic signed [VALUE_BITS-1:0]      value0,
  output logic [COUNT_BITS-1:0]             index0,
  output logic [COUNT_BITS-1:0]             index1
);

  localparam int MAG_BITS = VALUE_BITS - 1;
  localparam int ACC_BITS = VALUE_BITS + 3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BEFORE,
    PH_AFTER,
    PH_SIGN,
    PH_DIGITS,
    PH_DISCARD
  } phase_t;

  phase_t                phase, phase_next, ph1, sep_phase;
  logic [MAG_BITS-1:0]   mag, mag_next;
  logic                  neg, neg_next;
  logic [COUNT_BITS-1:0] cnt, cnt_next, cnt_inc, sep_count;
  logic [COUNT_BITS-1:0] expected_count;
  dilp_pkg::push_t       push_c;
  logic [COUNT_BITS-1:0] index0_c, index1_c;

  logic                  is_ws, is_digit, cnt_full, acc_ovf;
  logic [3:0]            digit;
  logic [ACC_BITS-1:0]   acc_wide;
  logic                  sep_emit;
  dilp_pkg::kind_t       sep_kind;
  logic                  fin_from_reg;
  logic [MAG_BITS-1:0]   fin_mag;
  logic                  fin_neg;
  logic [VALUE_BITS-1:0] fin_abs;

  assign is_ws    = (ch == dilp_pkg::CH_SPACE) ||
                    ((ch >= dilp_pkg::CH_WS_LO) && (ch <= dilp_pkg::CH_WS_HI));
  assign is_digit = (ch >= dilp_pkg::CH_ZERO) && (ch <= dilp_pkg::CH_NINE);
  assign digit    = ch[3:0];
  assign cnt_full = &cnt;
  assign cnt_inc  = cnt + COUNT_BITS'(1);

  // Magnitude times ten plus the new digit; too large once past the largest positive value.
  assign acc_wide = ACC_BITS'(mag) * ACC_BITS'(dilp_pkg::RADIX) + ACC_BITS'(digit);
  assign acc_ovf  = acc_wide > ACC_BITS'({MAG_BITS{1'b1}});

  // Separator handling, shared by the gap phases and by a number ended by a non-digit.
  assign sep_count = (phase == PH_DIGITS) ? cnt_inc : cnt;

  always_comb begin
    sep_emit  = 1'b0;
    sep_kind  = dilp_pkg::KIND_SYNTAX;
    sep_phase = PH_DISCARD;
    if (is_ws) begin
      sep_phase = (phase == PH_BEFORE) ? PH_BEFORE : PH_AFTER;
    end else if ((ch == dilp_pkg::CH_COMMA) && (phase != PH_BEFORE)) begin
      sep_phase = PH_BEFORE;
    end else if (ch == dilp_pkg::CH_CLOSE) begin
      sep_emit = 1'b1;
      sep_kind = (sep_count == expected_count) ? dilp_pkg::KIND_OK
                                               : dilp_pkg::KIND_MISMATCH;
    end else if (ch == dilp_pkg::CH_MINUS) begin
      sep_phase = PH_SIGN;
    end else if (is_digit) begin
      sep_phase = PH_DIGITS;
    end else begin
      sep_emit = 1'b1;
    end
  end

  always_comb begin
    ph1          = phase;
    mag_next     = mag;
    neg_next     = neg;
    cnt_next     = cnt;
    push_c       = '0;
    index0_c     = cnt;
    index1_c     = cnt;
    fin_from_reg = 1'b0;

    unique case (phase)
      PH_IDLE: begin
        if (ch == dilp_pkg::CH_OPEN) begin
          ph1      = PH_BEFORE;
          cnt_next = '0;
          mag_next = '0;
          neg_next = 1'b0;
        end else begin
          push_c.push0 = 1'b1;
          push_c.kind0 = dilp_pkg::KIND_SYNTAX;
          ph1          = PH_DISCARD;
        end
      end
      PH_BEFORE, PH_AFTER: begin
        ph1          = sep_phase;
        push_c.push0 = sep_emit;
        push_c.kind0 = sep_kind;
        if (ch == dilp_pkg::CH_MINUS) begin
          neg_next = 1'b1;
          mag_next = '0;
        end else if (is_digit) begin
          // A fresh number starts from zero, so one digit never overflows.
          neg_next = 1'b0;
          mag_next = MAG_BITS'(digit);
        end
      end
      PH_SIGN, PH_DIGITS: begin
        if (is_digit) begin
          if (acc_ovf) begin
            push_c.push0 = 1'b1;
            push_c.kind0 = dilp_pkg::KIND_OVERFLOW;
            ph1          = PH_DISCARD;
          end else begin
            mag_next = acc_wide[MAG_BITS-1:0];
            ph1      = PH_DIGITS;
          end
        end else if (phase == PH_SIGN) begin
          push_c.push0 = 1'b1;
          push_c.kind0 = dilp_pkg::KIND_SYNTAX;
          ph1          = PH_DISCARD;
        end else if (cnt_full) begin
          push_c.push0 = 1'b1;
          push_c.kind0 = dilp_pkg::KIND_OVERFLOW;
          ph1          = PH_DISCARD;
        end else begin
          // The number ends here; the same byte is then taken as a separator.
          push_c.push0 = 1'b1;
          push_c.kind0 = dilp_pkg::KIND_VALUE;
          fin_from_reg = 1'b1;
          cnt_next     = cnt_inc;
          push_c.push1 = sep_emit;
          push_c.kind1 = sep_kind;
          index1_c     = cnt_inc;
          ph1          = sep_phase;
          if (ch == dilp_pkg::CH_MINUS) begin
            neg_next = 1'b1;
            mag_next = '0;
          end
        end
      end
      PH_DISCARD: begin
        ph1 = PH_DISCARD;
      end
      default: begin
        ph1 = PH_DISCARD;
      end
    endcase

    if (end_of_text) begin
      if (ph1 == PH_DIGITS) begin
        // Nothing was emitted on the way into the number phase.
        push_c.push0 = 1'b1;
        index0_c     = cnt;
        if (cnt_full) begin
          push_c.kind0 = dilp_pkg::KIND_OVERFLOW;
        end else begin
          // The value is finished, but the list is still open.
          push_c.kind0 = dilp_pkg::KIND_VALUE;
          cnt_next     = cnt_inc;
          push_c.push1 = 1'b1;
          push_c.kind1 = dilp_pkg::KIND_TRUNC;
          index1_c     = cnt_inc;
        end
      end else if ((ph1 == PH_BEFORE) || (ph1 == PH_AFTER) || (ph1 == PH_SIGN)) begin
        if (push_c.push0) begin
          push_c.push1 = 1'b1;
          push_c.kind1 = dilp_pkg::KIND_TRUNC;
          index1_c     = cnt_next;
        end else begin
          push_c.push0 = 1'b1;
          push_c.kind0 = dilp_pkg::KIND_TRUNC;
          index0_c     = cnt_next;
        end
      end
      ph1 = PH_IDLE;
    end

    phase_next = ph1;
  end

  assign fin_mag = fin_from_reg ? mag : mag_next;
  assign fin_neg = fin_from_reg ? neg : neg_next;
  assign fin_abs = VALUE_BITS'(fin_mag);

  always_comb begin
    push   = push_c;
    index0 = index0_c;
    index1 = index1_c;
    value0 = '0;
    if (push_c.kind0 == dilp_pkg::KIND_VALUE) begin
      value0 = fin_neg ? -fin_abs : fin_abs;
    end
    if (!accept) begin
      push.push0 = 1'b0;
      push.push1 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      mag            <= '0;
      neg            <= 1'b0;
      cnt            <= '0;
      expected_count <= '0;
    end else begin
      if (cfg_wr_en) begin
        expected_count <= cfg_wr_data;
      end
      if (accept) begin
        phase <= phase_next;
        mag   <= mag_next;
        neg   <= neg_next;
        cnt   <= cnt_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dilp_queue.sv
// Four-entry result queue that takes up to two results a cycle and hands out one.
`default_nettype none

module dilp_queue #(
  parameter int VALUE_BITS = dilp_pkg::VALUE_BITS_DEFAULT,
  parameter int COUNT_BITS = dilp_pkg::COUNT_BITS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire dilp_pkg::push_t              push,
  input  wire logic signed [VALUE_BITS-1:0] value0,
  input  wire logic [COUNT_BITS-1:0]        index0,
  input  wire logic [COUNT_BITS-1:0]        index1,
  output logic                              room,
  dilp_result_if.source                     result
);

  localparam int DEPTH     = 4;
  localparam int PTR_BITS  = $clog2(DEPTH);
  localparam int FILL_BITS = $clog2(DEPTH + 1);

  logic [2:0]                   kind_q  [DEPTH];
  logic signed [VALUE_BITS-1:0] value_q [DEPTH];
  logic [COUNT_BITS-1:0]        index_q [DEPTH];
  logic                         last_q  [DEPTH];

  logic [PTR_BITS-1:0]  wr_ptr, rd_ptr, wr_ptr1;
  logic [FILL_BITS-1:0] fill, fill_next;
  logic                 pop;

  assign wr_ptr1 = wr_ptr + PTR_BITS'(1);
  assign pop     = result.valid && result.ready;
  // A byte may bring two results, so take one only while two entries are free.
  assign room    = fill <= FILL_BITS'(DEPTH - 2);

  assign result.valid = fill != '0;
  assign result.kind  = kind_q[rd_ptr];
  assign result.value = value_q[rd_ptr];
  assign result.index = index_q[rd_ptr];
  assign result.last  = last_q[rd_ptr];

  always_comb begin
    fill_next = fill;
    if (push.push0) begin
      fill_next = fill_next + FILL_BITS'(1);
    end
    if (push.push1) begin
      fill_next = fill_next + FILL_BITS'(1);
    end
    if (pop) begin
      fill_next = fill_next - FILL_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      fill <= fill_next;
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_BITS'(1);
      end
      if (push.push0 && push.push1) begin
        wr_ptr <= wr_ptr + PTR_BITS'(2);
      end else if (push.push0) begin
        wr_ptr <= wr_ptr1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.push0) begin
      kind_q[wr_ptr]  <= push.kind0;
      value_q[wr_ptr] <= value0;
      index_q[wr_ptr] <= index0;
      last_q[wr_ptr]  <= !push.push1;
    end
    if (push.push1) begin
      kind_q[wr_ptr1]  <= push.kind1;
      value_q[wr_ptr1] <= '0;
      index_q[wr_ptr1] <= index1;
      last_q[wr_ptr1]  <= 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/decimal_int_list_parser.sv
// Top level of the decimal integer list parser: byte channel in, result channel out.
//
// The block takes one text byte per beat and parses a bracketed list of signed decimal
// integers, emitting each value with its index and a close, truncation, syntax or
// overflow result. A byte is decoded in the cycle it is accepted, with the parse state
// held in registers, so bytes stream in at one per cycle. Most bytes cause at most one
// result; a byte that ends a number and also closes the list, fails, or ends the text
// causes two, which leave the output one after the other. Results wait in a four-entry
// queue; a byte is taken only while two entries are free, so with the result side always
// ready the rate is one byte per cycle, dropping only when results back up. The user
// writes expected_count via cfg_wr_en and cfg_wr_data while idle; this is not enforced.
`default_nettype none

module decimal_int_list_parser #(
  parameter int VALUE_BITS = dilp_pkg::VALUE_BITS_DEFAULT,
  parameter int COUNT_BITS = dilp_pkg::COUNT_BITS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [COUNT_BITS-1:0] cfg_wr_data,
  dilp_byte_if.sink                  text,
  dilp_result_if.source              result
);

  dilp_pkg::push_t              push;
  logic signed [VALUE_BITS-1:0] value0;
  logic [COUNT_BITS-1:0]        index0, index1;
  logic                         room;
  logic                         accept;

  assign text.ready = room;
  assign accept     = text.valid && room;

  dilp_parser #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .ch          (text.ch),
    .end_of_text (text.end_of_text),
    .push        (push),
    .value0      (value0),
    .index0      (index0),
    .index1      (index1)
  );

  dilp_queue #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .value0 (value0),
    .index0 (index0),
    .index1 (index1),
    .room   (room),
    .result (result)
  );

endmodule

`default_nettype wire
